### src/dffc_pkg.sv
// shared types and constants for the duplicate frame filter cache
// used by dffc_cell and duplicate_frame_filter_cache; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dffc_pkg;

  localparam int KeyW        = 72;
  localparam int LifeW       = 8;
  localparam int IdxW        = 6;   // covers up to 64 entries
  localparam int MaxEntries  = 64;
  localparam int DefEntries  = 8;
  localparam int SlotW       = 3;
  localparam int OutDataW    = 8;
  localparam int ApbAddrW    = 3;
  localparam int ApbDataW    = 32;

  localparam logic [LifeW-1:0] LifeResetVal = 8'd8;
  localparam logic [LifeW-1:0] LifeCeiling  = '1;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [LifeW-1:0] life_t;
  typedef logic [IdxW-1:0]  idx_t;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_MAX_LIFETIME = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  // search word marching along the row of cells
  typedef struct packed {
    logic  valid;
    key_t  key;
    logic  hit;
    idx_t  hit_idx;
    life_t best_life;
    idx_t  best_idx;
  } probe_t;

  // update broadcast to every cell once the search is done
  typedef struct packed {
    logic  valid;
    logic  hit;
    idx_t  slot;
    key_t  key;
    life_t max_life;
  } commit_t;

endpackage

`default_nettype wire

### src/dffc_cell.sv
// one cache entry: stored key and lifetime, plus one stage of the search row
// depends on dffc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dffc_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  dffc_pkg::probe_t   probe_i,
  output dffc_pkg::probe_t   probe_o,
  input  dffc_pkg::commit_t  commit_i
);
  import dffc_pkg::*;

  localparam idx_t MyIdx = IdxW'(CELL_IDX);

  key_t   key_q, key_d;
  life_t  life_q, life_d, life_ld;
  probe_t probe_q, probe_d;
  logic   match, sel;

  // search stage: first match and first smallest lifetime win
  always_comb begin
    match   = (probe_i.key == key_q);
    probe_d = probe_i;
    if (!probe_i.hit && match) begin
      probe_d.hit     = 1'b1;
      probe_d.hit_idx = MyIdx;
    end
    if (life_q < probe_i.best_life) begin
      probe_d.best_life = life_q;
      probe_d.best_idx  = MyIdx;
    end
  end

  // update: reload selected entry, age everything on a miss
  always_comb begin
    sel     = commit_i.valid && (commit_i.slot == MyIdx);
    life_ld = sel ? commit_i.max_life : life_q;
    life_d  = life_ld;
    if (commit_i.valid && !commit_i.hit && (life_ld != '0)) begin
      life_d = life_ld - life_t'(1);
    end
    key_d = (sel && !commit_i.hit) ? commit_i.key : key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      life_q  <= '0;
      probe_q <= '0;
    end else begin
      key_q   <= key_d;
      life_q  <= life_d;
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

### src/duplicate_frame_filter_cache.sv
// top level of the duplicate frame filter cache: handshakes, control, config
// depends on dffc_pkg and dffc_cell
`timescale 1ns / 1ps
`default_nettype none

// usage
// - s_axis: one word per received frame header, the key of the frame
// - m_axis: one word per input word, duplicate flag and cache slot
// - apb: register 0 at byte address 0 is max_lifetime (reset 8)
// - the cache is a row of CACHE_ENTRIES cells; a search word enters cell 0
//   on acceptance and moves one cell per cycle, picking up the first
//   matching entry and the first entry with the smallest lifetime
// - once it leaves the last cell, the result is registered and the commit
//   state broadcasts the update to all cells and loads the output register
// - one word at a time: a new word is taken only after the previous search
//   word has walked the cell row and its update has been broadcast
// - s_axis_tready is high only between searches; a new word is taken while
//   the previous result still waits in the output register
// - if the receiver stalls, the finished search waits before updating the
//   cache until the output register is free; nothing is dropped
// - reset clears all keys and lifetimes to zero, so an all-zero key hits
//   entry 0 right after reset; no clearing pass is needed
module duplicate_frame_filter_cache #(
  parameter int CACHE_ENTRIES = dffc_pkg::DefEntries
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // fields from bit 0: dest_pan[15:0], dest_addr[31:16], src_pan[47:32],
  // src_addr[63:48], seq_num[71:64]
  input  wire  [dffc_pkg::KeyW-1:0]        s_axis_tdata,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // fields from bit 0: duplicate[0], slot[3:1], zero[7:4]
  output logic [dffc_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [dffc_pkg::ApbAddrW-1:0]    paddr,
  input  wire  [dffc_pkg::ApbDataW-1:0]    pwdata,
  output logic [dffc_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);
  import dffc_pkg::*;

  state_e  state_q, state_d;
  probe_t  chain [CACHE_ENTRIES+1];
  commit_t commit;
  life_t   max_life_q;
  logic    s_accept, cfg_write, reg_sel;
  logic    res_hit_q, res_hit_d;
  idx_t    res_slot_q, res_slot_d;
  key_t    res_key_q, res_key_d;
  logic    out_valid_q, out_valid_d;
  logic    out_dup_q, out_dup_d;
  logic [SlotW-1:0] out_slot_q, out_slot_d;
  logic    out_free;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[2] == REG_MAX_LIFETIME);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? ApbDataW'(max_life_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_life_q <= LifeResetVal;
    end else if (cfg_write) begin
      max_life_q <= pwdata[LifeW-1:0];
    end
  end

  // search word entering the row
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = s_accept;
    chain[0].key       = s_axis_tdata;
    chain[0].best_life = LifeCeiling;
  end

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    dffc_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .probe_i  (chain[g]),
      .probe_o  (chain[g+1]),
      .commit_i (commit)
    );
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // control
  always_comb begin
    state_d     = state_q;
    res_hit_d   = res_hit_q;
    res_slot_d  = res_slot_q;
    res_key_d   = res_key_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_dup_d   = out_dup_q;
    out_slot_d  = out_slot_q;
    commit      = '0;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // result captured as the word leaves the last cell
        if (chain[CACHE_ENTRIES].valid) begin
          res_hit_d  = chain[CACHE_ENTRIES].hit;
          res_slot_d = chain[CACHE_ENTRIES].hit ? chain[CACHE_ENTRIES].hit_idx
                                                : chain[CACHE_ENTRIES].best_idx;
          res_key_d  = chain[CACHE_ENTRIES].key;
          state_d    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          commit.valid    = 1'b1;
          commit.hit      = res_hit_q;
          commit.slot     = res_slot_q;
          commit.key      = res_key_q;
          commit.max_life = max_life_q;
          out_valid_d     = 1'b1;
          out_dup_d       = res_hit_q;
          out_slot_d      = res_slot_q[SlotW-1:0];
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q  <= res_hit_d;
    res_slot_q <= res_slot_d;
    res_key_q  <= res_key_d;
    out_dup_q  <= out_dup_d;
    out_slot_q <= out_slot_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-SlotW-1){1'b0}}, out_slot_q, out_dup_q};

  // checks
  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[CACHE_ENTRIES].valid |-> (state_q == S_SCAN))
    else $error("search word left the row outside a search");

  a_commit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit.valid |=> (m_axis_tvalid && (m_axis_tdata[0] == $past(res_hit_q))))
    else $error("update without matching result word");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> (int'(res_slot_q) < CACHE_ENTRIES))
    else $error("selected slot beyond the cache");

  a_no_accept_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !chain[0].valid)
    else $error("second word entered the row during a search");

endmodule

`default_nettype wire
